// ===== src/ccem_pkg.sv =====
// shared types, constants and compare functions of the color change edge marker
// no dependencies; every other file of the block but ccem_line_ram imports this package
package ccem_pkg;

   // frame limits and the widths that follow from them
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // fixed field widths
   localparam int CHAN_W    = 8;
   localparam int THR_W     = 10;
   localparam int QB_W      = 4;
   localparam int DIM_W     = 11;
   localparam int POS_W     = 10;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   // register reset values
   localparam logic [THR_W-1:0] RESET_THRESHOLD    = 10'd1;
   localparam logic [QB_W-1:0]  RESET_QUANT_BITS   = 4'd1;
   localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 11'd1024;

   // marked color
   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
   localparam logic [CHAN_W-1:0] CHAN_NONE = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD    = 8'd0,
      CSR_QUANT_BITS   = 8'd1,
      CSR_IMAGE_WIDTH  = 8'd2,
      CSR_IMAGE_HEIGHT = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [QB_W-1:0]  quant_bits;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   // one accepted pixel with its position and row/column flags
   typedef struct packed {
      pixel_type        px;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             has_above;
      logic             last_col;
      logic             last_row;
   } stage_type;

   // one result waiting at the output
   typedef struct packed {
      pixel_type        px;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             marked;
   } result_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // true when two pixels count as a color change under the current mode
   function automatic logic px_differs(input pixel_type a, input pixel_type b,
                                       input logic [THR_W-1:0] thr,
                                       input logic [QB_W-1:0] qb);
      logic [THR_W-1:0]  sum;
      logic [QB_W-1:0]   q;
      logic [CHAN_W-1:0] keep;
      logic              code_diff;
      sum = THR_W'(abs_diff(a.red, b.red)) + THR_W'(abs_diff(a.green, b.green))
          + THR_W'(abs_diff(a.blue, b.blue));
      if (qb == '0) begin
         q = QB_W'(1);
      end else if (qb > QB_W'(CHAN_W)) begin
         q = QB_W'(CHAN_W);
      end else begin
         q = qb;
      end
      keep = CHAN_W'({CHAN_W{1'b1}} << (QB_W'(CHAN_W) - q));
      code_diff = (((a.red ^ b.red) & keep) != '0)
               || (((a.green ^ b.green) & keep) != '0)
               || (((a.blue ^ b.blue) & keep) != '0);
      return (thr != '0) ? (sum > thr) : code_diff;
   endfunction

endpackage

// ===== src/ccem_if.sv =====
// handshake channels of the color change edge marker: pixel in, result out, register write
// depends on ccem_pkg for field widths

interface ccem_req_if import ccem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic [CHAN_W-1:0] alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface ccem_rsp_if import ccem_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic [CHAN_W-1:0] alpha_out;
   logic [POS_W-1:0]  out_column;
   logic [POS_W-1:0]  out_row;
   logic              marked;
   logic              run_last;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, out_column,
                   out_row, marked, run_last, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, out_column,
                   out_row, marked, run_last, output ready);
endinterface

interface ccem_csr_if import ccem_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/color_change_edge_marker.sv =====
// top level of the color change edge marker: register file and pipeline wiring
// depends on ccem_pkg, ccem_if, ccem_front, ccem_mark and ccem_out
//
// Pixels enter in raster order, one per clock while results are taken, and each is
// compared with its right neighbour and the pixel below; a changed pixel is sent out as
// pure red with its alpha. A pixel's result leaves when the pixel below it arrives, so
// row 0 gives no results, a middle row one result per pixel (the pixel above), and the
// last row two (the pixel above, then the current one, with run_last on the second).
// A result passes the input register, then the result register; the second result of a
// last-row pixel follows once the first is taken, and the single result port holds a new
// pixel until both have left. The previous row lives in one 1024 x 32 line store with one
// write and two read ports; it needs no clearing after reset. Registers must be written
// only while idle; the block does not enforce it.
module color_change_edge_marker import ccem_pkg::*; (
   input logic        clock,
   input logic        reset,
   ccem_req_if.sink   req_bus,
   ccem_rsp_if.source rsp_bus,
   ccem_csr_if.sink   csr_bus
);

   cfg_type   cfg_ff, cfg_in;
   stage_type stage;
   pixel_type above_px, right_px;
   logic      stage_valid, take, mark_hit, csr_write;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_bus.index)
            CSR_THRESHOLD:    cfg_in.threshold    = THR_W'(csr_bus.data);
            CSR_QUANT_BITS:   cfg_in.quant_bits   = QB_W'(csr_bus.data);
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = DIM_W'(csr_bus.data);
            CSR_IMAGE_HEIGHT: cfg_in.image_height = DIM_W'(csr_bus.data);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{threshold: RESET_THRESHOLD, quant_bits: RESET_QUANT_BITS,
                     image_width: RESET_IMAGE_WIDTH, image_height: RESET_IMAGE_HEIGHT};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register and line store
   ccem_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_bus     (req_bus),
      .take        (take),
      .stage_valid (stage_valid),
      .stage       (stage),
      .above_px    (above_px),
      .right_px    (right_px)
   );

   // color change decision
   ccem_mark u_mark (
      .cfg      (cfg_ff),
      .stage    (stage),
      .above_px (above_px),
      .right_px (right_px),
      .mark_hit (mark_hit)
   );

   // result register
   ccem_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .above_px    (above_px),
      .mark_hit    (mark_hit),
      .take        (take),
      .rsp_bus     (rsp_bus)
   );

endmodule

// ===== src/ccem_line_ram.sv =====
// generic single-write, dual-read memory with registered read data (read-first)
// no dependencies
module ccem_line_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // two read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== src/ccem_front.sv =====
// input stage: raster counters, input register and the previous-row line store
// depends on ccem_pkg, ccem_if and ccem_line_ram
module ccem_front import ccem_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   ccem_req_if.sink   req_bus,
   input  logic       take,
   output logic       stage_valid,
   output stage_type  stage,
   output pixel_type  above_px,
   output pixel_type  right_px
);

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in, w_last, col, col_next;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in, h_last, row;
   logic             stage_valid_ff, stage_valid_in;
   stage_type        stage_ff;
   pixel_type        in_px;
   logic             last_col, last_row, accept;

   // last column and last row after clamping the frame size
   always_comb begin
      if (cfg.image_width == '0) begin
         w_last = '0;
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(cfg.image_width - DIM_W'(1));
      end
      if (cfg.image_height == '0) begin
         h_last = '0;
      end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(cfg.image_height - DIM_W'(1));
      end
   end

   // current position, a counter past the bound counts as the last one
   assign col      = (col_cnt_ff > w_last) ? w_last : col_cnt_ff;
   assign row      = (row_cnt_ff > h_last) ? h_last : row_cnt_ff;
   assign last_col = (col == w_last);
   assign last_row = (row == h_last);
   assign col_next = COL_W'(col + 1'b1);

   assign in_px = '{alpha: req_bus.alpha_in, blue: req_bus.blue_in,
                    green: req_bus.green_in, red: req_bus.red_in};

   // handshake: take a new item when the stage is empty or moving on
   assign req_bus.ready = !stage_valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   // raster counters
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = last_row ? '0 : ROW_W'(row + 1'b1);
         end else begin
            col_cnt_in = col_next;
            row_cnt_in = row;
         end
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (take) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff     <= '0;
         row_cnt_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff     <= col_cnt_in;
         row_cnt_ff     <= row_cnt_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= '{px: in_px, col: col, row: row, has_above: (row != '0),
                       last_col: last_col, last_row: last_row};
      end
   end

   // line store: read pixel above and its right neighbour, then overwrite with this pixel
   ccem_line_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col),
      .wr_data   (in_px),
      .rd_en     (accept),
      .rd_addr_a (col),
      .rd_addr_b (col_next),
      .rd_data_a (above_px),
      .rd_data_b (right_px)
   );

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   // a stalled stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !take |=> stage_valid_ff && $stable(stage_ff))
      else $error("input stage lost or changed its item while stalled");

   // an empty stage always takes an item
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> req_bus.ready)
      else $error("input stage empty but not ready");

endmodule

// ===== src/ccem_mark.sv =====
// color change decision for the pixel above: right neighbour and pixel below
// depends on ccem_pkg
module ccem_mark import ccem_pkg::*; (
   input  cfg_type   cfg,
   input  stage_type stage,
   input  pixel_type above_px,
   input  pixel_type right_px,
   output logic      mark_hit
);

   logic right_diff, below_diff;

   // both compares use the unmarked colors; last column never marks
   assign right_diff = px_differs(above_px, right_px, cfg.threshold, cfg.quant_bits);
   assign below_diff = px_differs(above_px, stage.px, cfg.threshold, cfg.quant_bits);
   assign mark_hit   = !stage.last_col && (right_diff || below_diff);

endmodule

// ===== src/ccem_out.sv =====
// result register: holds the pixel above and, on the last row, the current pixel
// depends on ccem_pkg and ccem_if
module ccem_out import ccem_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      stage_valid,
   input  stage_type stage,
   input  pixel_type above_px,
   input  logic      mark_hit,
   output logic      take,
   ccem_rsp_if.source rsp_bus
);

   logic       has_above_ff, has_above_in;
   logic       has_cur_ff, has_cur_in;
   result_type above_ff, cur_ff, shown;
   pixel_type  above_shown;
   logic       rsp_accept, load;

   assign rsp_accept = rsp_bus.valid && rsp_bus.ready;

   // free when empty, or when the last held result leaves this cycle
   assign take = (!has_above_ff && !has_cur_ff)
              || (rsp_accept && (has_above_ff != has_cur_ff));
   assign load = stage_valid && take;

   always_comb begin
      has_above_in = has_above_ff;
      has_cur_in   = has_cur_ff;
      if (load) begin
         has_above_in = stage.has_above;
         has_cur_in   = stage.last_row;
      end else if (rsp_accept) begin
         if (has_above_ff) begin
            has_above_in = 1'b0;
         end else begin
            has_cur_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_above_ff <= 1'b0;
         has_cur_ff   <= 1'b0;
      end else begin
         has_above_ff <= has_above_in;
         has_cur_ff   <= has_cur_in;
      end
   end

   // recolor the pixel above when marked
   always_comb begin
      above_shown = above_px;
      if (mark_hit) begin
         above_shown.red   = CHAN_FULL;
         above_shown.green = CHAN_NONE;
         above_shown.blue  = CHAN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         above_ff <= '{px: above_shown, col: POS_W'(stage.col),
                       row: POS_W'(stage.row - 1'b1), marked: mark_hit};
         cur_ff   <= '{px: stage.px, col: POS_W'(stage.col),
                       row: POS_W'(stage.row), marked: 1'b0};
      end
   end

   // the pixel above goes out first
   assign shown = has_above_ff ? above_ff : cur_ff;

   assign rsp_bus.valid      = has_above_ff || has_cur_ff;
   assign rsp_bus.red_out    = shown.px.red;
   assign rsp_bus.green_out  = shown.px.green;
   assign rsp_bus.blue_out   = shown.px.blue;
   assign rsp_bus.alpha_out  = shown.px.alpha;
   assign rsp_bus.out_column = shown.col;
   assign rsp_bus.out_row    = shown.row;
   assign rsp_bus.marked     = shown.marked;
   assign rsp_bus.run_last   = has_above_ff ? !has_cur_ff : 1'b1;

   // a first result is followed by the current pixel one row down
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !rsp_bus.run_last |=> rsp_bus.valid && rsp_bus.run_last
         && (rsp_bus.out_column == $past(rsp_bus.out_column))
         && (rsp_bus.out_row == POS_W'($past(rsp_bus.out_row) + 1'b1)))
      else $error("second result of a last-row item out of order");

   // the current pixel of the last row is never recolored
   a_cur_unmarked: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !has_above_ff |-> !rsp_bus.marked)
      else $error("last-row pixel shown as marked");

endmodule

// ===== bench/tb_top.sv =====
// testbench of the color change edge marker: raster frames of rgba pixels are checked
// against an own prediction of every result, with random idling on the pixel and result channels
// depends on ccem_pkg, ccem_if and the block top color_change_edge_marker
module tb_top import ccem_pkg::*; ();

   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PIXELS  = 800;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [CSR_IDX_W-1:0] SPARE_INDEX_FIRST = CSR_IDX_W'(CSR_IMAGE_HEIGHT + 1);

   // one result pixel as the block should send it
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic [POS_W-1:0]  column;
      logic [POS_W-1:0]  row;
      logic              marked;
      logic              run_last;
   } pixel_result_type;

   logic clock;
   logic reset;

   ccem_req_if req_bus ();
   ccem_rsp_if rsp_bus ();
   ccem_csr_if csr_bus ();

   color_change_edge_marker u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted state of the block
   pixel_type        line_store [MAX_WIDTH];
   int unsigned      next_col = 0;
   int unsigned      next_row = 0;
   logic [THR_W-1:0] cfg_threshold;
   logic [QB_W-1:0]  cfg_quant_bits;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   pixel_result_type expected_results [$];

   pixel_type last_sent = '0;
   bit        steady = 1'b0;
   bit        hold_results = 1'b0;
   int        fail_count = 0;
   int        sent_pixels = 0;
   int        result_count = 0;
   int        marked_count = 0;
   int        frame_count = 0;
   int        write_count = 0;
   int        idle_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 2);
      if (roll < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 50);
   endfunction

   function automatic int unsigned random_threshold();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return 0;
      if (roll < 80) return $urandom_range(1, 120);
      if (roll < 95) return $urandom_range(121, 765);
      return $urandom_range(766, 1023);
   endfunction

   function automatic int chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   // color change test: summed distance in threshold mode, kept top bits in code mode
   function automatic bit colors_change(pixel_type a, pixel_type b);
      int sum;
      int shift;
      if (cfg_threshold != 0) begin
         sum = chan_gap(a.red, b.red) + chan_gap(a.green, b.green) + chan_gap(a.blue, b.blue);
         return sum > int'(cfg_threshold);
      end
      shift = CHAN_W - ((cfg_quant_bits == 0) ? 1 :
                        (cfg_quant_bits > CHAN_W) ? CHAN_W : int'(cfg_quant_bits));
      return ((a.red >> shift) != (b.red >> shift))
          || ((a.green >> shift) != (b.green >> shift))
          || ((a.blue >> shift) != (b.blue >> shift));
   endfunction

   function automatic pixel_result_type make_result(pixel_type p, bit mark,
                                                    int unsigned col, int unsigned row);
      pixel_result_type res;
      res.red      = mark ? CHAN_FULL : p.red;
      res.green    = mark ? CHAN_NONE : p.green;
      res.blue     = mark ? CHAN_NONE : p.blue;
      res.alpha    = p.alpha;
      res.column   = POS_W'(col);
      res.row      = POS_W'(row);
      res.marked   = mark;
      res.run_last = 1'b0;
      return res;
   endfunction

   // results caused by one accepted pixel, and the state update behind them
   function automatic void predict_pixel(pixel_type px);
      int unsigned      width;
      int unsigned      height;
      int unsigned      col;
      int unsigned      row;
      bit               at_last_col;
      bit               at_last_row;
      bit               mark;
      pixel_type        above;
      pixel_result_type step_results [$];
      width  = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      height = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
      col    = (next_col > width - 1) ? width - 1 : next_col;
      row    = (next_row > height - 1) ? height - 1 : next_row;
      at_last_col = (col == width - 1);
      at_last_row = (row == height - 1);
      // the pixel above leaves once the one below it is here
      if (row > 0) begin
         above = line_store[col];
         mark  = !at_last_col
              && (colors_change(above, line_store[col + 1]) || colors_change(above, px));
         step_results.push_back(make_result(above, mark, col, row - 1));
      end
      if (at_last_row) begin
         step_results.push_back(make_result(px, 1'b0, col, row));
      end
      if (step_results.size() > 0) begin
         step_results[step_results.size() - 1].run_last = 1'b1;
      end
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
      line_store[col] = px;
      if (at_last_col) begin
         next_col = 0;
         next_row = at_last_row ? 0 : row + 1;
      end else begin
         next_col = col + 1;
         next_row = row;
      end
   endfunction

   // random content: fresh, copies of the left or upper neighbour, or small jitter
   function automatic pixel_type random_pixel();
      pixel_type p;
      pixel_type base;
      int        roll;
      p    = $urandom;
      roll = $urandom_range(0, 9);
      if (roll < 3 || (roll >= 5 && roll <= 8 && next_row == 0)) return p;
      base = (roll >= 5 && roll <= 8) ? line_store[next_col] : last_sent;
      if (roll <= 6) return base;
      base.red   = base.red + CHAN_W'($urandom_range(0, 6)) - CHAN_W'(3);
      base.green = base.green + CHAN_W'($urandom_range(0, 6)) - CHAN_W'(3);
      base.blue  = base.blue + CHAN_W'($urandom_range(0, 6)) - CHAN_W'(3);
      base.alpha = p.alpha;
      return base;
   endfunction

   function automatic pixel_type gray(logic [CHAN_W-1:0] level, logic [CHAN_W-1:0] alpha);
      pixel_type p;
      p.red   = level;
      p.green = level;
      p.blue  = level;
      p.alpha = alpha;
      return p;
   endfunction

   // offer one pixel after an optional gap and wait for it to be taken
   task automatic send_pixel(pixel_type px);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.red_in   <= px.red;
      req_bus.green_in <= px.green;
      req_bus.blue_in  <= px.blue;
      req_bus.alpha_in <= px.alpha;
      do @(posedge clock); while (!req_bus.ready);
      predict_pixel(px);
      last_sent = px;
      sent_pixels++;
      @(negedge clock);
   endtask

   // random pixels until the position counters wrap to the frame start
   task automatic send_frame();
      do send_pixel(random_pixel()); while (next_col != 0 || next_row != 0);
      frame_count++;
   endtask

   // one register write; upper data bits are sometimes junk that the block must drop
   task automatic write_register(logic [CSR_IDX_W-1:0] reg_index, int unsigned value, bit more);
      int unsigned data;
      int          field_w;
      case (reg_index)
         CSR_THRESHOLD:  field_w = THR_W;
         CSR_QUANT_BITS: field_w = QB_W;
         default:        field_w = DIM_W;
      endcase
      data = value;
      if ($urandom_range(0, 7) == 0) data = data | ($urandom << field_w);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= CSR_DAT_W'(data);
      do @(posedge clock); while (!csr_bus.ready);
      case (reg_index)
         CSR_THRESHOLD:    cfg_threshold  = THR_W'(data);
         CSR_QUANT_BITS:   cfg_quant_bits = QB_W'(data);
         CSR_IMAGE_WIDTH:  cfg_width      = DIM_W'(data);
         CSR_IMAGE_HEIGHT: cfg_height     = DIM_W'(data);
         default: ;
      endcase
      write_count++;
      @(negedge clock);
      if (!more) csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(int unsigned threshold, int unsigned quant_bits,
                            int unsigned width, int unsigned height);
      // now and then a write to an index with no register behind it
      if ($urandom_range(0, 4) == 0) begin
         write_register(CSR_IDX_W'($urandom_range(SPARE_INDEX_FIRST, 255)), $urandom, 1'b1);
      end
      write_register(CSR_THRESHOLD, threshold, 1'b1);
      write_register(CSR_QUANT_BITS, quant_bits, 1'b1);
      write_register(CSR_IMAGE_WIDTH, width, 1'b1);
      write_register(CSR_IMAGE_HEIGHT, height, 1'b0);
   endtask

   // all results in, then room for a pixel that causes none
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_values_wide_frame();
      // threshold and quant bits keep their reset values; the first row runs at the
      // reset width, then a narrower width ends it and sets the second row
      write_register(CSR_IMAGE_HEIGHT, 2, 1'b0);
      repeat (40) send_pixel(random_pixel());
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, 40, 1'b0);
      send_frame();
      wait_idle();
   endtask

   task automatic test_threshold_extremes();
      int unsigned limits [2] = '{765, 764};
      // black and white checkerboard: distance 765, marked only below the top limit
      foreach (limits[k]) begin
         configure(limits[k], 1, 3, 2);
         for (int i = 0; i < 6; i++) begin
            send_pixel(gray((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF));
         end
         wait_idle();
      end
   endtask

   task automatic test_code_mode();
      logic [CHAN_W-1:0] levels [8] = '{8'h00, 8'h7F, 8'h80, 8'h7F,
                                        8'h00, 8'h01, 8'h00, 8'h00};
      // quant bits at 1 from the previous test: only the top bit of each channel counts
      write_register(CSR_THRESHOLD, 0, 1'b1);
      write_register(CSR_IMAGE_WIDTH, 2, 1'b1);
      write_register(CSR_IMAGE_HEIGHT, 2, 1'b0);
      for (int i = 0; i < 8; i++) begin
         // full precision for the second frame: the lowest bit counts
         if (i == 4) begin
            wait_idle();
            write_register(CSR_QUANT_BITS, 8, 1'b0);
         end
         send_pixel(gray(levels[i], CHAN_W'(i * 37)));
      end
      wait_idle();
   endtask

   task automatic test_degenerate_settings();
      // zero sizes act as one, oversize threshold never marks, quant bits saturate
      configure(1023, 0, 0, 0);
      send_frame();
      send_frame();
      wait_idle();
      configure(0, 15, 1, 1);
      send_frame();
      send_frame();
      wait_idle();
   endtask

   task automatic test_single_line_frames();
      configure(random_threshold(), $urandom_range(0, 15), $urandom_range(2, 40), 1);
      send_frame();
      wait_idle();
      configure(random_threshold(), $urandom_range(0, 15), 1, $urandom_range(2, 40));
      send_frame();
      wait_idle();
   endtask

   task automatic test_tall_frame();
      // height beyond the limit is used as the largest frame; a lower height later
      // turns the row reached into the last one
      configure(random_threshold(), $urandom_range(0, 15), 1, 2047);
      repeat (30) send_pixel(random_pixel());
      wait_idle();
      write_register(CSR_IMAGE_HEIGHT, 31, 1'b0);
      send_frame();
      wait_idle();
   endtask

   task automatic test_geometry_change_mid_frame();
      // shrink below the position reached: counters act as last column and last row
      configure(random_threshold(), $urandom_range(0, 15), 8, 6);
      repeat (21) send_pixel(random_pixel());
      wait_idle();
      configure(random_threshold(), $urandom_range(0, 15), 4, 3);
      send_frame();
      wait_idle();
      // grow the height once the first row is in
      configure(random_threshold(), $urandom_range(0, 15), 5, 2);
      repeat (5) send_pixel(random_pixel());
      wait_idle();
      configure(random_threshold(), $urandom_range(0, 15), 5, 4);
      send_frame();
      wait_idle();
   endtask

   task automatic test_output_stall();
      // results held off for a long stretch while pixels keep coming
      configure(random_threshold(), $urandom_range(0, 15), 12, 20);
      steady       = 1'b1;
      hold_results = 1'b1;
      send_frame();
      steady = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_frames();
      int goal;
      int width;
      goal = sent_pixels + RANDOM_PIXELS;
      while (sent_pixels < goal) begin
         width = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         configure(random_threshold(), $urandom_range(0, 15), width, $urandom_range(1, 10));
         steady = ($urandom_range(0, 3) == 0);
         send_frame();
         wait_idle();
      end
      steady = 1'b0;
   endtask

   // result receiver: random stalls, one long hold on request
   initial begin
      int gap;
      forever begin
         if (hold_results) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   function automatic bit field_matches(string name, logic [15:0] want_v, logic [15:0] got_v,
                                        pixel_result_type want);
      if (want_v === got_v) return 1'b1;
      if (fail_count < REPORT_LIMIT) begin
         $display("%s of pixel at column %0d row %0d: expected %0d, got %0d",
                  name, want.column, want.row, want_v, got_v);
      end
      return 1'b0;
   endfunction

   // result checker
   always @(posedge clock) begin
      pixel_result_type want;
      bit               bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT) begin
               $display("result with nothing expected at column %0d row %0d",
                        rsp_bus.out_column, rsp_bus.out_row);
            end
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            bad  = 1'b0;
            bad |= !field_matches("red", 16'(want.red), 16'(rsp_bus.red_out), want);
            bad |= !field_matches("green", 16'(want.green), 16'(rsp_bus.green_out), want);
            bad |= !field_matches("blue", 16'(want.blue), 16'(rsp_bus.blue_out), want);
            bad |= !field_matches("alpha", 16'(want.alpha), 16'(rsp_bus.alpha_out), want);
            bad |= !field_matches("column", 16'(want.column), 16'(rsp_bus.out_column),
                                  want);
            bad |= !field_matches("row", 16'(want.row), 16'(rsp_bus.out_row), want);
            bad |= !field_matches("marked", 16'(want.marked), 16'(rsp_bus.marked), want);
            bad |= !field_matches("run_last", 16'(want.run_last), 16'(rsp_bus.run_last),
                                  want);
            if (bad) fail_count++;
            if (want.marked) marked_count++;
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no item moved for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      req_bus.alpha_in = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      cfg_threshold    = RESET_THRESHOLD;
      cfg_quant_bits   = RESET_QUANT_BITS;
      cfg_width        = RESET_IMAGE_WIDTH;
      cfg_height       = RESET_IMAGE_HEIGHT;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values_wide_frame();
      test_threshold_extremes();
      test_code_mode();
      test_degenerate_settings();
      test_single_line_frames();
      test_tall_frame();
      test_geometry_change_mid_frame();
      test_output_stall();
      test_random_frames();
      wait_idle();

      $display("%0d pixels in %0d generated frames and the directed ones, %0d results checked",
               sent_pixels, frame_count, result_count);
      $display("%0d results marked, %0d register writes, %0d failing results",
               marked_count, write_count, fail_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
